### sv/blt_pkg.sv
// Bouncing line trail: shared constants, types and helper functions.
// Used by the top level bouncing_line_trail and by its testbench.
package blt_pkg;

  localparam int RING_LINES = 20;
  localparam int MAX_SPEED  = 6;
  localparam int IDX_W      = (RING_LINES > 1) ? $clog2(RING_LINES) : 1;
  localparam int ADDR_W     = 3;

  // register index, taken from paddr[2]
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [7:0] WIDTH_RESET  = 8'd128;
  localparam logic [7:0] HEIGHT_RESET = 8'd64;

  // coordinate k: 0 = x0, 1 = y0, 2 = x1, 3 = y1 (odd k bounces on height)
  typedef struct packed {
    logic [3:0][3:0] vel;
    logic [3:0][7:0] pos;
  } seg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_ERASE,
    S_LD_ERASE,
    S_RD_HEAD,
    S_LD_HEAD,
    S_STEP,
    S_WRITE,
    S_RD_SEG,
    S_LD_SEG
  } state_t;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    if (i == IDX_W'(RING_LINES - 1)) begin
      return '0;
    end
    return i + 1'b1;
  endfunction

  function automatic logic [2:0] clamp_speed(input logic [2:0] s);
    if (s == 3'd0) begin
      return 3'd1;
    end
    if (s > 3'(MAX_SPEED - 1)) begin
      return 3'(MAX_SPEED - 1);
    end
    return s;
  endfunction

endpackage

### sv/blt_step.sv
// Bounce step for one coordinate: move by velocity, reverse with a new
// magnitude when leaving 0..bound, then saturate. Shared over the four coordinates.
// No package dependencies.
module blt_step (
  input  logic [7:0]        pos,
  input  logic signed [3:0] vel,
  input  logic [7:0]        bound,
  input  logic [2:0]        speed,
  output logic [7:0]        pos_next,
  output logic signed [3:0] vel_next
);

  logic signed [9:0] ext_pos;
  logic signed [9:0] ext_bnd;
  logic signed [9:0] n0;
  logic signed [9:0] n;
  logic signed [3:0] sp4;
  logic signed [3:0] nv;
  logic              out_of;

  always_comb begin
    ext_pos = signed'({2'b00, pos});
    ext_bnd = signed'({2'b00, bound});
    sp4     = signed'({1'b0, speed});
    n0      = ext_pos + signed'({{6{vel[3]}}, vel});
    out_of  = (n0 < 10'sd0) || (n0 > ext_bnd);
    if (vel > 4'sd0) begin
      nv = -sp4;
    end else if (vel < 4'sd0) begin
      nv = sp4;
    end else begin
      nv = 4'sd0;
    end
    if (out_of) begin
      vel_next = nv;
      n        = ext_pos + signed'({{6{nv[3]}}, nv});
    end else begin
      vel_next = vel;
      n        = n0;
    end
    if (n < 10'sd0) begin
      pos_next = 8'd0;
    end else if (n > ext_bnd) begin
      pos_next = bound;
    end else begin
      pos_next = n[7:0];
    end
  end

endmodule

### sv/bouncing_line_trail.sv
// Bouncing line trail top level: APB registers, segment ring, sequencer.
// Depends on blt_pkg and blt_step.
//
//   channel | direction | handshake          | word
//   --------+-----------+--------------------+-------------------------------------
//   in      | input     | in_valid/in_stall  | rand_x0..y1, rand_speed_a..d
//   out     | output    | out_valid/out_stall| seg_x0..y1, is_erase, last_segment
//   apb     | config    | psel/penable/pready| screen_width (0x0), screen_height (0x4)
//
// One frame tick gives RING_LINES+1 words; the block takes no new tick until
// the last word of the previous tick has been loaded for output.
// Each word goes through a read state on the single ring read port, then a load state;
// the four coordinates go one per cycle through the shared step unit.
// Reset is synchronous; the ring reads as zero until written (valid bits).
// Output stall holds the sequencer at the next load; in_stall is high while busy.
module bouncing_line_trail (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [blt_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 rand_x0,
  input  logic [7:0]                 rand_y0,
  input  logic [7:0]                 rand_x1,
  input  logic [7:0]                 rand_y1,
  input  logic [2:0]                 rand_speed_a,
  input  logic [2:0]                 rand_speed_b,
  input  logic [2:0]                 rand_speed_c,
  input  logic [2:0]                 rand_speed_d,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 seg_x0,
  output logic [7:0]                 seg_y0,
  output logic [7:0]                 seg_x1,
  output logic [7:0]                 seg_y1,
  output logic                       is_erase,
  output logic                       last_segment
);

  blt_pkg::state_t state;
  blt_pkg::state_t state_next;

  logic [7:0]                  screen_width;
  logic [7:0]                  screen_height;
  logic                        seeded;
  logic [blt_pkg::IDX_W-1:0]   head;
  logic [blt_pkg::IDX_W-1:0]   ptr;
  logic [blt_pkg::IDX_W-1:0]   cnt;
  logic [1:0]                  k;
  logic [3:0][2:0]             sp;
  blt_pkg::seg_t               cur;
  blt_pkg::seg_t               mem [blt_pkg::RING_LINES];
  logic [blt_pkg::RING_LINES-1:0] valid;
  blt_pkg::seg_t               rdata;
  logic                        rvld;

  logic                        accept;
  logic                        out_free;
  logic                        apb_wr;
  logic                        rd_en;
  logic [blt_pkg::IDX_W-1:0]   raddr;
  logic                        wr_en;
  logic [blt_pkg::IDX_W-1:0]   waddr;
  blt_pkg::seg_t               wdata;
  logic                        seed;
  logic                        out_load;
  logic                        load_erase;
  blt_pkg::seg_t               seed_seg;
  logic [7:0]                  step_pos;
  logic [3:0]                  step_vel;

  assign pready   = 1'b1;
  assign in_stall = (state != blt_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign apb_wr   = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      blt_pkg::REG_WIDTH:  prdata = {24'd0, screen_width};
      blt_pkg::REG_HEIGHT: prdata = {24'd0, screen_height};
      default:             prdata = 32'd0;
    endcase
  end

  always_comb begin
    seed_seg.pos = {rand_y1, rand_x1, rand_y0, rand_x0};
    seed_seg.vel = {{1'b0, blt_pkg::clamp_speed(rand_speed_d)},
                    {1'b0, blt_pkg::clamp_speed(rand_speed_c)},
                    {1'b0, blt_pkg::clamp_speed(rand_speed_b)},
                    {1'b0, blt_pkg::clamp_speed(rand_speed_a)}};
  end

  blt_step u_step (
    .pos      (cur.pos[k]),
    .vel      (cur.vel[k]),
    .bound    (k[0] ? screen_height : screen_width),
    .speed    (sp[k]),
    .pos_next (step_pos),
    .vel_next (step_vel)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      blt_pkg::S_IDLE:     if (accept) state_next = blt_pkg::S_RD_ERASE;
      blt_pkg::S_RD_ERASE: state_next = blt_pkg::S_LD_ERASE;
      blt_pkg::S_LD_ERASE: if (out_free) state_next = blt_pkg::S_RD_HEAD;
      blt_pkg::S_RD_HEAD:  state_next = blt_pkg::S_LD_HEAD;
      blt_pkg::S_LD_HEAD:  state_next = blt_pkg::S_STEP;
      blt_pkg::S_STEP:     if (k == 2'd3) state_next = blt_pkg::S_WRITE;
      blt_pkg::S_WRITE:    state_next = blt_pkg::S_RD_SEG;
      blt_pkg::S_RD_SEG:   state_next = blt_pkg::S_LD_SEG;
      blt_pkg::S_LD_SEG: begin
        if (out_free) begin
          if (cnt == blt_pkg::IDX_W'(blt_pkg::RING_LINES - 1)) begin
            state_next = blt_pkg::S_IDLE;
          end else begin
            state_next = blt_pkg::S_RD_SEG;
          end
        end
      end
      default:             state_next = blt_pkg::S_IDLE;
    endcase
  end

  // sequencer strobes
  always_comb begin
    rd_en      = 1'b0;
    raddr      = ptr;
    wr_en      = 1'b0;
    waddr      = blt_pkg::next_idx(head);
    wdata      = cur;
    seed       = 1'b0;
    out_load   = 1'b0;
    load_erase = 1'b0;
    unique case (state)
      blt_pkg::S_IDLE: begin
        if (accept && !seeded) begin
          seed  = 1'b1;
          wr_en = 1'b1;
          waddr = blt_pkg::IDX_W'(blt_pkg::RING_LINES - 1);
          wdata = seed_seg;
        end
      end
      blt_pkg::S_RD_ERASE: begin
        rd_en = 1'b1;
        raddr = blt_pkg::next_idx(head);
      end
      blt_pkg::S_LD_ERASE: begin
        out_load   = out_free;
        load_erase = 1'b1;
      end
      blt_pkg::S_RD_HEAD: begin
        rd_en = 1'b1;
        raddr = head;
      end
      blt_pkg::S_WRITE:  wr_en = 1'b1;
      blt_pkg::S_RD_SEG: rd_en = 1'b1;
      blt_pkg::S_LD_SEG: out_load = out_free;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= blt_pkg::S_IDLE;
      seeded        <= 1'b0;
      head          <= blt_pkg::IDX_W'(blt_pkg::RING_LINES - 1);
      out_valid     <= 1'b0;
      valid         <= '0;
      screen_width  <= blt_pkg::WIDTH_RESET;
      screen_height <= blt_pkg::HEIGHT_RESET;
      ptr           <= '0;
      cnt           <= '0;
      k             <= '0;
    end else begin
      state <= state_next;
      if (apb_wr) begin
        if (paddr[2] == blt_pkg::REG_WIDTH) begin
          screen_width <= pwdata[7:0];
        end else begin
          screen_height <= pwdata[7:0];
        end
      end
      // seeding empties the ring but for the seeded head slot (the top one)
      if (seed) begin
        seeded <= 1'b1;
        head   <= waddr;
        valid  <= {1'b1, {(blt_pkg::RING_LINES - 1){1'b0}}};
      end else if (wr_en) begin
        valid[waddr] <= 1'b1;
      end
      if (state == blt_pkg::S_WRITE) begin
        head <= waddr;
        ptr  <= blt_pkg::next_idx(waddr);
        cnt  <= '0;
      end
      if (state == blt_pkg::S_LD_SEG && out_free) begin
        ptr <= blt_pkg::next_idx(ptr);
        cnt <= cnt + 1'b1;
      end
      if (state == blt_pkg::S_LD_HEAD) begin
        k <= '0;
      end else if (state == blt_pkg::S_STEP) begin
        k <= k + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers and ring memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
      rvld  <= valid[raddr];
    end
    if (accept) begin
      sp <= {blt_pkg::clamp_speed(rand_speed_d), blt_pkg::clamp_speed(rand_speed_c),
             blt_pkg::clamp_speed(rand_speed_b), blt_pkg::clamp_speed(rand_speed_a)};
    end
    if (state == blt_pkg::S_LD_HEAD) begin
      cur <= rvld ? rdata : '0;
    end else if (state == blt_pkg::S_STEP) begin
      cur.pos[k] <= step_pos;
      cur.vel[k] <= step_vel;
    end
    if (out_load) begin
      seg_x0       <= rvld ? rdata.pos[0] : 8'd0;
      seg_y0       <= rvld ? rdata.pos[1] : 8'd0;
      seg_x1       <= rvld ? rdata.pos[2] : 8'd0;
      seg_y1       <= rvld ? rdata.pos[3] : 8'd0;
      is_erase     <= load_erase;
      last_segment <= !load_erase && (cnt == blt_pkg::IDX_W'(blt_pkg::RING_LINES - 1));
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == blt_pkg::S_RD_ERASE)
    else $error("accepted word did not start the erase read");

  a_head_advance: assert property (@(posedge clk) disable iff (rst)
    state == blt_pkg::S_WRITE |=> head == blt_pkg::next_idx($past(head)))
    else $error("head did not advance by one slot");

  a_step_done: assert property (@(posedge clk) disable iff (rst)
    (state == blt_pkg::S_STEP && k == 2'd3) |=> state == blt_pkg::S_WRITE)
    else $error("step sequence did not end in the write");

  a_seeded_holds: assert property (@(posedge clk) disable iff (rst)
    seeded |=> seeded)
    else $error("seeded flag dropped");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || !out_stall))
    else $error("output register overwritten while stalled");

endmodule

### sim/tb_bouncing_line_trail.sv
`timescale 1ns / 1ps
// Testbench for bouncing_line_trail: frame ticks against a built-in trail predictor,
// with screen-size writes over APB between phases. Depends on blt_pkg and the RTL.
module tb_bouncing_line_trail;

  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES  = 60;
  localparam int RANDOM_TICKS  = 330;
  localparam int PHASES        = 7;

  localparam logic [blt_pkg::ADDR_W-1:0] WIDTH_ADDR  = {blt_pkg::REG_WIDTH, 2'b00};
  localparam logic [blt_pkg::ADDR_W-1:0] HEIGHT_ADDR = {blt_pkg::REG_HEIGHT, 2'b00};

  typedef struct packed {
    logic [7:0] x0;
    logic [7:0] y0;
    logic [7:0] x1;
    logic [7:0] y1;
    logic [2:0] sa;
    logic [2:0] sb;
    logic [2:0] sc;
    logic [2:0] sd;
  } tick_t;

  typedef struct packed {
    logic [7:0] x0;
    logic [7:0] y0;
    logic [7:0] x1;
    logic [7:0] y1;
    logic       erase;
    logic       last;
  } segment_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [blt_pkg::ADDR_W-1:0] paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;
  logic                       in_valid;
  logic                       in_stall;
  logic [7:0]                 rand_x0;
  logic [7:0]                 rand_y0;
  logic [7:0]                 rand_x1;
  logic [7:0]                 rand_y1;
  logic [2:0]                 rand_speed_a;
  logic [2:0]                 rand_speed_b;
  logic [2:0]                 rand_speed_c;
  logic [2:0]                 rand_speed_d;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [7:0]                 seg_x0;
  logic [7:0]                 seg_y0;
  logic [7:0]                 seg_x1;
  logic [7:0]                 seg_y1;
  logic                       is_erase;
  logic                       last_segment;

  // trail predictor state
  int       trail_pos [blt_pkg::RING_LINES][4];
  int       trail_vel [blt_pkg::RING_LINES][4];
  int       trail_head;
  bit       trail_seeded;
  int       screen_w;
  int       screen_h;
  segment_t pending_segments[$];

  int mismatches = 0;
  int quiet_cycles = 0;
  bit hold_req = 1'b0;
  int stall_left = 0;
  int free_left = 0;
  int stall_roll;

  bouncing_line_trail dut (.*);

  always #2 clk = ~clk;

  function automatic int eff_speed(input logic [2:0] code);
    if (code == 3'd0) begin
      return 1;
    end
    if (code > blt_pkg::MAX_SPEED - 1) begin
      return blt_pkg::MAX_SPEED - 1;
    end
    return code;
  endfunction

  function automatic void push_segment(input int slot, input logic erase, input logic last);
    segment_t s;
    s.x0 = 8'(trail_pos[slot][0]);
    s.y0 = 8'(trail_pos[slot][1]);
    s.x1 = 8'(trail_pos[slot][2]);
    s.y1 = 8'(trail_pos[slot][3]);
    s.erase = erase;
    s.last = last;
    pending_segments.push_back(s);
  endfunction

  // coordinate k: 0 = x0, 1 = y0, 2 = x1, 3 = y1; odd k bounces on height
  function automatic void predict_tick(input tick_t t);
    int spd [4];
    int pos;
    int vel;
    int bound;
    int nh;
    spd[0] = eff_speed(t.sa);
    spd[1] = eff_speed(t.sb);
    spd[2] = eff_speed(t.sc);
    spd[3] = eff_speed(t.sd);
    if (!trail_seeded) begin
      foreach (trail_pos[i, k]) begin
        trail_pos[i][k] = 0;
        trail_vel[i][k] = 0;
      end
      trail_head = blt_pkg::RING_LINES - 1;
      trail_pos[trail_head][0] = t.x0;
      trail_pos[trail_head][1] = t.y0;
      trail_pos[trail_head][2] = t.x1;
      trail_pos[trail_head][3] = t.y1;
      for (int k = 0; k < 4; k++) begin
        trail_vel[trail_head][k] = spd[k];
      end
      trail_seeded = 1'b1;
    end
    nh = (trail_head + 1) % blt_pkg::RING_LINES;
    // oldest line goes out first, before the head overwrites its slot
    push_segment(nh, 1'b1, 1'b0);
    for (int k = 0; k < 4; k++) begin
      pos = trail_pos[trail_head][k];
      vel = trail_vel[trail_head][k];
      bound = (k % 2 == 1) ? screen_h : screen_w;
      if (pos + vel < 0 || pos + vel > bound) begin
        vel = (vel > 0) ? -spd[k] : ((vel < 0) ? spd[k] : 0);
      end
      pos = pos + vel;
      if (pos < 0) begin
        pos = 0;
      end
      if (pos > bound) begin
        pos = bound;
      end
      trail_pos[nh][k] = pos;
      trail_vel[nh][k] = vel;
    end
    trail_head = nh;
    for (int i = 0; i < blt_pkg::RING_LINES; i++) begin
      push_segment((nh + 1 + i) % blt_pkg::RING_LINES, 1'b0, i == blt_pkg::RING_LINES - 1);
    end
  endfunction

  task automatic check_segment();
    segment_t want;
    if (pending_segments.size() == 0) begin
      $error("segment word with nothing expected: %0d,%0d-%0d,%0d", seg_x0, seg_y0,
             seg_x1, seg_y1);
      mismatches++;
    end else begin
      want = pending_segments.pop_front();
      if (seg_x0 !== want.x0) begin
        $error("seg_x0: expected %0d, got %0d", want.x0, seg_x0);
        mismatches++;
      end
      if (seg_y0 !== want.y0) begin
        $error("seg_y0: expected %0d, got %0d", want.y0, seg_y0);
        mismatches++;
      end
      if (seg_x1 !== want.x1) begin
        $error("seg_x1: expected %0d, got %0d", want.x1, seg_x1);
        mismatches++;
      end
      if (seg_y1 !== want.y1) begin
        $error("seg_y1: expected %0d, got %0d", want.y1, seg_y1);
        mismatches++;
      end
      if (is_erase !== want.erase) begin
        $error("is_erase: expected %0d, got %0d", want.erase, is_erase);
        mismatches++;
      end
      if (last_segment !== want.last) begin
        $error("last_segment: expected %0d, got %0d", want.last, last_segment);
        mismatches++;
      end
    end
  endtask

  // receiver: checks each word, then picks short stalls, long stalls or free runs
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_segment();
      end
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && free_left == 0) begin
        stall_roll = $urandom_range(0, 99);
        if (stall_roll < 55) begin
          free_left = $urandom_range(1, 6);
        end else if (stall_roll < 65) begin
          free_left = $urandom_range(30, 120);
        end else if (stall_roll < 93) begin
          stall_left = $urandom_range(1, 3);
        end else begin
          stall_left = $urandom_range(8, 40);
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        free_left--;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic logic [2:0] random_speed();
    if ($urandom_range(0, 99) < 85) begin
      return 3'($urandom_range(1, 5));
    end
    return 3'($urandom_range(0, 7));
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    t.x0 = 8'($urandom_range(0, 255));
    t.y0 = 8'($urandom_range(0, 255));
    t.x1 = 8'($urandom_range(0, 255));
    t.y1 = 8'($urandom_range(0, 255));
    t.sa = random_speed();
    t.sb = random_speed();
    t.sc = random_speed();
    t.sd = random_speed();
    return t;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      return 0;
    end
    if (roll < 80) begin
      return $urandom_range(1, 8);
    end
    return $urandom_range(9, 90);
  endfunction

  // called at a rising edge; returns at the edge where the word is taken
  task automatic send_tick(input tick_t t, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rand_x0 <= t.x0;
    rand_y0 <= t.y0;
    rand_x1 <= t.x1;
    rand_y1 <= t.y1;
    rand_speed_a <= t.sa;
    rand_speed_b <= t.sb;
    rand_speed_c <= t.sc;
    rand_speed_d <= t.sd;
    do begin
      @(posedge clk);
    end while (!(in_valid && !in_stall));
    predict_tick(t);
  endtask

  task automatic write_reg(input logic [blt_pkg::ADDR_W-1:0] addr, input logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {24'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    if (addr == WIDTH_ADDR) begin
      screen_w = value;
    end else if (addr == HEIGHT_ADDR) begin
      screen_h = value;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_segments.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic set_screen(input logic [7:0] w, input logic [7:0] h);
    wait_drained();
    // let the sequencer get back to idle after the last word
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(WIDTH_ADDR, w);
    write_reg(HEIGHT_ADDR, h);
  endtask

  // first tick seeds beyond the default screen with out-of-range speeds
  task automatic test_seed_and_extremes();
    tick_t t;
    t.x0 = 8'hFF;
    t.y0 = 8'hFF;
    t.x1 = 8'hFF;
    t.y1 = 8'hFF;
    t.sa = 3'd0;
    t.sb = 3'd7;
    t.sc = 3'd6;
    t.sd = 3'd5;
    send_tick(t, 0);
    for (int i = 0; i < 8; i++) begin
      t.x0 = (i % 2 == 1) ? 8'hFF : 8'h00;
      t.y0 = ~t.x0;
      t.x1 = t.x0;
      t.y1 = ~t.x0;
      t.sa = 3'(i);
      t.sb = 3'(7 - i);
      t.sc = 3'(i + 3);
      t.sd = 3'(i + 5);
      send_tick(t, (i < 4) ? 0 : pick_gap());
    end
  endtask

  task automatic test_tiny_screens();
    logic [7:0] widths [4];
    logic [7:0] heights [4];
    widths = '{8'd0, 8'd1, 8'd255, 8'd1};
    heights = '{8'd1, 8'd0, 8'd255, 8'd1};
    for (int s = 0; s < 4; s++) begin
      set_screen(widths[s], heights[s]);
      for (int i = 0; i < 3; i++) begin
        send_tick(random_tick(), pick_gap());
      end
    end
  endtask

  // output held off while ticks keep coming, so the block has to stall its input
  task automatic test_backpressure();
    set_screen(8'd20, 8'd12);
    hold_req = 1'b1;
    for (int i = 0; i < 8; i++) begin
      send_tick(random_tick(), 0);
    end
    wait_drained();
  endtask

  task automatic test_random_ticks(input int count);
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          set_screen(8'd255, 8'd255);
        end
        2: begin
          set_screen(8'd1, 8'd255);
        end
        4: begin
          set_screen(8'd255, 8'd1);
        end
        1, 5: begin
          set_screen(8'($urandom_range(2, 16)), 8'($urandom_range(2, 16)));
        end
        default: begin
          set_screen(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
        end
      endcase
      for (int i = 0; i < count / PHASES; i++) begin
        send_tick(random_tick(), pick_gap());
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    rand_x0 = '0;
    rand_y0 = '0;
    rand_x1 = '0;
    rand_y1 = '0;
    rand_speed_a = '0;
    rand_speed_b = '0;
    rand_speed_c = '0;
    rand_speed_d = '0;
    screen_w = blt_pkg::WIDTH_RESET;
    screen_h = blt_pkg::HEIGHT_RESET;
    trail_head = blt_pkg::RING_LINES - 1;
    trail_seeded = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_seed_and_extremes();
    test_tiny_screens();
    test_backpressure();
    test_random_ticks(RANDOM_TICKS);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### sim.f
sv/blt_pkg.sv
sv/blt_step.sv
sv/bouncing_line_trail.sv
sim/tb_bouncing_line_trail.sv
